/* hdl/vts_pkg.sv */
// vts_pkg: shared widths, axis factor codes and the decode result struct
// for the variation tuple scalar block. No dependencies.
package vts_pkg;

   // F2Dot14 field width and divider operand width
   localparam int COORD_W = 16;
   localparam int DIV_W   = 16;

   // default number of fraction bits in factors and products
   localparam int FRACTION_BITS_DEF = 16;

   // axis factor kinds
   localparam logic [1:0] FACT_ONE   = 2'd0;
   localparam logic [1:0] FACT_ZERO  = 2'd1;
   localparam logic [1:0] FACT_RATIO = 2'd2;

   // decoded axis: what kind of factor, and divider operands for a ramp
   typedef struct packed {
      logic [1:0]       kind;
      logic [DIV_W-1:0] numer;
      logic [DIV_W-1:0] denom;
   } vts_axis_type;

endpackage

/* hdl/vts_axis_decode.sv */
// vts_axis_decode: classifies one axis (coordinate against start/peak/end)
// and forms the ramp numerator and denominator. Depends on vts_pkg.
module vts_axis_decode import vts_pkg::*; (
   input  logic signed [COORD_W-1:0] coordinate,
   input  logic signed [COORD_W-1:0] region_start,
   input  logic signed [COORD_W-1:0] region_peak,
   input  logic signed [COORD_W-1:0] region_end,
   output vts_axis_type              axis
);

   // signed differences, one bit wider; all needed ones fit 0..32768
   logic signed [COORD_W:0] c_minus_s;
   logic signed [COORD_W:0] p_minus_s;
   logic signed [COORD_W:0] e_minus_c;
   logic signed [COORD_W:0] e_minus_p;

   assign c_minus_s = {coordinate[COORD_W-1], coordinate}
                      - {region_start[COORD_W-1], region_start};
   assign p_minus_s = {region_peak[COORD_W-1], region_peak}
                      - {region_start[COORD_W-1], region_start};
   assign e_minus_c = {region_end[COORD_W-1], region_end}
                      - {coordinate[COORD_W-1], coordinate};
   assign e_minus_p = {region_end[COORD_W-1], region_end}
                      - {region_peak[COORD_W-1], region_peak};

   // factor selection
   always_comb begin
      logic bad_region;
      bad_region = (region_start > region_peak) || (region_peak > region_end)
                   || ((region_start < 0) && (region_end > 0) && (region_peak != 0))
                   || (region_peak == 0);
      axis.kind  = FACT_ONE;
      axis.numer = '0;
      axis.denom = '0;
      if (bad_region) begin
         axis.kind = FACT_ONE;
      end else if ((coordinate < region_start) || (coordinate > region_end)) begin
         axis.kind = FACT_ZERO;
      end else if (coordinate == region_peak) begin
         axis.kind = FACT_ONE;
      end else if (coordinate < region_peak) begin
         if (region_peak != region_start) begin
            axis.kind  = FACT_RATIO;
            axis.numer = c_minus_s[DIV_W-1:0];
            axis.denom = p_minus_s[DIV_W-1:0];
         end
      end else begin
         if (region_end != region_peak) begin
            axis.kind  = FACT_RATIO;
            axis.numer = e_minus_c[DIV_W-1:0];
            axis.denom = e_minus_p[DIV_W-1:0];
         end
      end
   end

endmodule

/* hdl/vts_restoring_div.sv */
// vts_restoring_div: restoring divider, one quotient bit per cycle, for a
// fraction numer/denom with numer < denom. Depends on vts_pkg.
module vts_restoring_div import vts_pkg::*; #(
   parameter int QUO_W = FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] numer,
   input  logic [DIV_W-1:0] denom,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [DIV_W-1:0] rem_ff,  rem_in;
   logic [DIV_W-1:0] den_ff,  den_in;
   logic [QUO_W-1:0] quo_ff,  quo_in;

   logic [DIV_W:0] trial;
   logic [DIV_W:0] diff;
   logic           fits;

   // one shift-compare-subtract step
   assign trial = {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
         rem_in  = numer;
         den_in  = denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/variation_tuple_scalar.sv */
// variation_tuple_scalar: top level. Sequencer, running product and its
// multiplier, result register. Uses vts_pkg, vts_axis_decode, vts_restoring_div.
//
//  channel | direction | words                          | handshake
//  req_    | in        | one axis: coordinate, region   | req_valid / req_ready
//  rsp_    | out       | tuple scalar, one per tuple    | rsp_valid / rsp_ready
//
// Each axis word steps through accept, decode, the shared restoring divider,
// multiply and update. Axes whose factor is zero or one skip the divider.
// req_ready is high only while the sequencer is idle. The result sits in an
// output register; a last axis waits in the update step while a previous
// result is still untaken. Synchronous reset sets the running product to one.
module variation_tuple_scalar import vts_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_coordinate,
   input  logic signed [COORD_W-1:0] req_region_start,
   input  logic signed [COORD_W-1:0] req_region_peak,
   input  logic signed [COORD_W-1:0] req_region_end,
   input  logic                      req_last_axis,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [FRACTION_BITS:0]    rsp_tuple_scalar
);

   localparam int FW = FRACTION_BITS + 1;
   localparam int MW = 2 * FW;
   localparam logic [FW-1:0] ONE_VALUE = {1'b1, {FRACTION_BITS{1'b0}}};

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLASS = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;

   logic [2:0] state_ff, state_in;

   logic signed [COORD_W-1:0] coord_ff, start_ff, peak_ff, end_ff;
   logic                      last_ff;

   logic [FW-1:0] product_ff, product_in;
   logic [FW-1:0] factor_ff,  factor_in;
   logic [MW-1:0] mul_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_data_ff,  rsp_data_in;

   vts_axis_type             axis;
   logic                     div_start;
   logic                     div_done;
   logic [FRACTION_BITS-1:0] div_quo;
   logic [FW-1:0]            scaled;
   logic                     rsp_free;

   // axis classification on the captured word
   vts_axis_decode u_decode (
      .coordinate   (coord_ff),
      .region_start (start_ff),
      .region_peak  (peak_ff),
      .region_end   (end_ff),
      .axis         (axis)
   );

   assign div_start = (state_ff == S_CLASS) && (axis.kind == FACT_RATIO);

   // shared divider for the ramp fraction
   vts_restoring_div #(
      .QUO_W (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (axis.numer),
      .denom    (axis.denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   // product of two values up to one reaches bit MW-2
   assign scaled    = mul_ff[MW-2:FRACTION_BITS];

   // sequencer and running product
   always_comb begin
      state_in     = state_ff;
      product_in   = product_ff;
      factor_in    = factor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            case (axis.kind)
               FACT_ZERO: begin
                  factor_in = '0;
                  state_in  = S_MUL;
               end
               FACT_RATIO: begin
                  state_in = S_DIV;
               end
               default: begin
                  factor_in = ONE_VALUE;
                  state_in  = S_MUL;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               factor_in = {1'b0, div_quo};
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (!last_ff) begin
               product_in = scaled;
               state_in   = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = scaled;
               product_in   = ONE_VALUE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         product_ff   <= ONE_VALUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         product_ff   <= product_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      factor_ff   <= factor_in;
      rsp_data_ff <= rsp_data_in;
      mul_ff      <= product_ff * factor_ff;
   end

   // capture the axis word on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         coord_ff <= req_coordinate;
         start_ff <= req_region_start;
         peak_ff  <= req_region_peak;
         end_ff   <= req_region_end;
         last_ff  <= req_last_axis;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tuple_scalar = rsp_data_ff;

   // running product never exceeds one
   a_product_le_one: assert property (@(posedge clock) disable iff (reset)
      product_ff <= ONE_VALUE)
      else $error("running product above one");

   // divider finishes only while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside divide step");

   // emitting a result restarts the product at one
   a_emit_resets_product: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && last_ff && rsp_free) |=>
         (product_ff == ONE_VALUE && rsp_valid_ff))
      else $error("product not reset after result");

endmodule
